/* src/bdr_pkg.sv */
package bdr_pkg;

  localparam int PIN_W = 3;
  localparam int IDX_W = 2;
  localparam int CNT_W = 16;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_TICK  = 2'd0;
  localparam cmd_t CMD_PRESS = 2'd1;
  localparam cmd_t CMD_HOLD  = 2'd2;

  localparam logic CFG_PRESSED_LEVEL = 1'b0;
  localparam logic CFG_HOLD_TICKS    = 1'b1;

  localparam logic [CNT_W-1:0] HOLD_TICKS_RST    = 16'd100;
  localparam logic             PRESSED_LEVEL_RST = 1'b0;

  // Per-lane control from the top level for one accepted transaction.
  typedef struct packed {
    logic tick;
    logic clr_press;
    logic clr_hold;
  } lane_ctl_t;

  // Per-lane status toward the merging stage.
  typedef struct packed {
    logic press_pending;
    logic hold_pending;
    logic stable_nxt;
  } lane_stat_t;

endpackage

/* src/bdr_lane.sv */
module bdr_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pressed_level,
  input  logic [bdr_pkg::CNT_W-1:0]   hold_ticks,
  input  logic                        level,
  input  bdr_pkg::lane_ctl_t          ctl,
  output bdr_pkg::lane_stat_t         stat
);

  logic [2:0]                hist_r, hist_nxt;
  logic                      stable_r, stable_nxt;
  logic [bdr_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [bdr_pkg::CNT_W-1:0] cnt_dec;
  logic                      press_r, press_nxt;
  logic                      hold_r, hold_nxt;
  logic                      agree;

  assign cnt_dec = cnt_r - 16'd1;
  // The history after the shift agrees when the two kept samples match the new one.
  assign agree   = (hist_r[1] == hist_r[2]) && (hist_r[2] == level);

  always_comb begin
    hist_nxt   = hist_r;
    stable_nxt = stable_r;
    cnt_nxt    = cnt_r;
    press_nxt  = press_r;
    hold_nxt   = hold_r;
    if (ctl.tick) begin
      hist_nxt = {level, hist_r[2:1]};
      if (agree) begin
        if (stable_r != level) begin
          stable_nxt = level;
          if (level == pressed_level) begin
            press_nxt = 1'b1;
            cnt_nxt   = hold_ticks;
          end
        end else if (level == pressed_level) begin
          if (cnt_dec == '0) begin
            hold_nxt = 1'b1;
            cnt_nxt  = hold_ticks;
          end else begin
            cnt_nxt = cnt_dec;
          end
        end
      end
    end
    if (ctl.clr_press) begin
      press_nxt = 1'b0;
    end
    if (ctl.clr_hold) begin
      hold_nxt = 1'b0;
    end
  end

  // Reset puts every sample at the released level of the reset pressed level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r   <= {3{~bdr_pkg::PRESSED_LEVEL_RST}};
      stable_r <= ~bdr_pkg::PRESSED_LEVEL_RST;
      cnt_r    <= bdr_pkg::HOLD_TICKS_RST;
      press_r  <= 1'b0;
      hold_r   <= 1'b0;
    end else begin
      hist_r   <= hist_nxt;
      stable_r <= stable_nxt;
      cnt_r    <= cnt_nxt;
      press_r  <= press_nxt;
      hold_r   <= hold_nxt;
    end
  end

  assign stat.press_pending = press_r;
  assign stat.hold_pending  = hold_r;
  assign stat.stable_nxt    = stable_nxt;

  a_stable_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.tick |=> $stable(stable_r))
    else $error("stable level changed without a sample tick");

  a_press_on_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(press_r) |-> (stable_r == pressed_level) && !$stable(stable_r))
    else $error("press flag set without a change to the pressed level");

  a_hold_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(hold_r) |-> (stable_r == pressed_level) && $past(ctl.tick))
    else $error("hold flag set while not pressed");

endmodule

/* src/bdr_merge.sv */
module bdr_merge #(
  parameter int NUM_BUTTONS = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_command,
  input  logic [bdr_pkg::IDX_W-1:0]         in_button_index,
  output logic                              in_acc,
  input  bdr_pkg::lane_stat_t               stat [NUM_BUTTONS],
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_event_seen,
  output logic [bdr_pkg::PIN_W-1:0]         out_stable_levels
);

  logic                        seen;
  logic [bdr_pkg::PIN_W-1:0]   stable_bits;
  logic                        out_valid_r, out_valid_nxt;
  logic                        skid_valid_r, skid_valid_nxt;
  logic                        out_seen_r, skid_seen_r;
  logic [bdr_pkg::PIN_W-1:0]   out_stable_r, skid_stable_r;
  logic                        out_take;
  logic                        load_main, load_skid;

  // Pick the polled lane's flag; an index past the last lane matches nothing.
  always_comb begin
    seen = 1'b0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (32'(in_button_index) == b) begin
        if (in_command == bdr_pkg::CMD_PRESS) begin
          seen = stat[b].press_pending;
        end else if (in_command == bdr_pkg::CMD_HOLD) begin
          seen = stat[b].hold_pending;
        end
      end
    end
  end

  always_comb begin
    stable_bits = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (b < bdr_pkg::PIN_W) begin
        stable_bits[b] = stat[b].stable_nxt;
      end
    end
  end

  // Two-entry output buffer: the skid entry catches a transaction taken while
  // the output register is stalled, so in_stall comes straight from a flop.
  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_main      = 1'b0;
    load_skid      = 1'b0;
    if (!out_valid_r || out_take) begin
      out_valid_nxt  = skid_valid_r || in_acc;
      skid_valid_nxt = 1'b0;
      load_main      = !skid_valid_r && in_acc;
    end else if (in_acc) begin
      skid_valid_nxt = 1'b1;
      load_skid      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_main) begin
      out_seen_r   <= seen;
      out_stable_r <= stable_bits;
    end else if ((!out_valid_r || out_take) && skid_valid_r) begin
      out_seen_r   <= skid_seen_r;
      out_stable_r <= skid_stable_r;
    end
    if (load_skid) begin
      skid_seen_r   <= seen;
      skid_stable_r <= stable_bits;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_seen    = out_seen_r;
  assign out_stable_levels = out_stable_r;

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a transaction while the output register is empty");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled result was dropped");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_take) |=> (out_valid_r && !skid_valid_r))
    else $error("skid entry did not move to the output register");

endmodule

/* src/button_debounce_hold_repeat_top.sv */
// Results go to the output register, or to the skid entry while that one stalls.
// One transaction per cycle while in_stall is low; all lanes update in the same cycle.
// A two-entry output buffer keeps input acceptance going while one result is stalled.
// Reset (rst_n low, synchronous) clears flags, loads released levels into every lane,
// loads 100 into hold counters and restores both configuration registers.
module button_debounce_hold_repeat_top #(
  parameter int NUM_BUTTONS = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [bdr_pkg::CNT_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_command,
  input  logic [bdr_pkg::PIN_W-1:0]     in_pin_levels,
  input  logic [bdr_pkg::IDX_W-1:0]     in_button_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_event_seen,
  output logic [bdr_pkg::PIN_W-1:0]     out_stable_levels
);

  logic                        pressed_level_r;
  logic [bdr_pkg::CNT_W-1:0]   hold_ticks_r;
  logic                        in_acc;
  bdr_pkg::lane_ctl_t          ctl  [NUM_BUTTONS];
  bdr_pkg::lane_stat_t         stat [NUM_BUTTONS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_level_r <= bdr_pkg::PRESSED_LEVEL_RST;
      hold_ticks_r    <= bdr_pkg::HOLD_TICKS_RST;
    end else if (cfg_we) begin
      if (cfg_index == bdr_pkg::CFG_PRESSED_LEVEL) begin
        pressed_level_r <= cfg_wdata[0];
      end else begin
        hold_ticks_r <= cfg_wdata;
      end
    end
  end

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    logic lane_level;
    logic hit;

    // Lanes beyond the pin field sample a constant low level.
    if (b < bdr_pkg::PIN_W) begin : g_pin
      assign lane_level = in_pin_levels[b];
    end else begin : g_nopin
      assign lane_level = 1'b0;
    end

    assign hit = (32'(in_button_index) == b);
    assign ctl[b].tick      = in_acc && (in_command == bdr_pkg::CMD_TICK);
    assign ctl[b].clr_press = in_acc && hit && (in_command == bdr_pkg::CMD_PRESS);
    assign ctl[b].clr_hold  = in_acc && hit && (in_command == bdr_pkg::CMD_HOLD);

    bdr_lane u_lane (
      .clk           (clk),
      .rst_n         (rst_n),
      .pressed_level (pressed_level_r),
      .hold_ticks    (hold_ticks_r),
      .level         (lane_level),
      .ctl           (ctl[b]),
      .stat          (stat[b])
    );
  end

  bdr_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_button_index   (in_button_index),
    .in_acc            (in_acc),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_seen    (out_event_seen),
    .out_stable_levels (out_stable_levels)
  );

endmodule
